>>> design/ocpi_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// octree cell preorder index package
// shared widths, constants and helper functions of the preorder index block
// ----------------------------------------------------------------------------
package ocpi_pkg;

    localparam int AXIS_BITS  = 9;
    localparam int LEVEL_W    = 4;
    localparam int CODE_W     = 3 * AXIS_BITS;
    localparam int PARENT_W   = 7;
    localparam int INDEX_W    = 28;
    localparam int SHIFT_W    = 4;
    localparam int SHAMT_W    = 5;
    localparam int IN_DATA_W  = 32;
    localparam int OUT_DATA_W = 64;

    localparam logic [LEVEL_W-1:0] TOP_LEVEL_RESET = LEVEL_W'(8);
    localparam logic [LEVEL_W-1:0] TOP_LEVEL_MAX   = LEVEL_W'(AXIS_BITS - 1);
    localparam logic [LEVEL_W-1:0] TOP_LEVEL_MIN   = LEVEL_W'(1);

    typedef logic [AXIS_BITS-1:0] axis_t;
    typedef logic [CODE_W-1:0]    code_t;
    typedef logic [INDEX_W-1:0]   index_t;
    typedef logic [LEVEL_W-1:0]   level_t;

    // x at weight 1, z at weight 2, y at weight 4 in each octal digit
    function automatic code_t interleave(axis_t x, axis_t y, axis_t z);
        code_t code;
        code = '0;
        for (int b = 0; b < AXIS_BITS; b++)
        begin
            code[3*b]     = x[b];
            code[3*b + 1] = z[b];
            code[3*b + 2] = y[b];
        end
        return code;
    endfunction

    // preorder weight of digit k: (8^(k+1)-1)/7
    function automatic index_t digit_weight(int k);
        index_t w;
        w = index_t'(1);
        for (int i = 0; i < k; i++)
        begin
            w = (w << 3) + index_t'(1);
        end
        return w;
    endfunction

endpackage

>>> design/octree_cell_preorder_index.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// octree cell preorder index
// morton interleave, level masking and preorder index of an octree cell
// ----------------------------------------------------------------------------
// usage:
//   s_tdata carries one cell per transaction (x, y, z grid coordinates and
//   the level below the root); m_tdata returns the masked morton code, the
//   parent-offset field and the depth-first preorder index of the cell.
//   cfg_wr_en / cfg_wr_data set top_level (octree levels, root included);
//   write it only while no transaction is in flight.
//   a transaction passes the three register stages in order: interleave and
//   clamp, mask and weighted partial sums, final sum. throughput is one
//   transaction per cycle while the receiver keeps m_tready high.
//   when the receiver holds m_tready low, the stages fill up behind the
//   output register and s_tready falls once every stage holds a transaction;
//   nothing is dropped or repeated.
//   reset clears all valid bits and sets top_level to 8.
// ----------------------------------------------------------------------------
module octree_cell_preorder_index
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_wr_en,
    input  logic [ocpi_pkg::LEVEL_W-1:0]     cfg_wr_data,   // top_level
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // grid_x[8:0], grid_y[17:9], grid_z[26:18], level_offset[30:27], zero
    input  logic [ocpi_pkg::IN_DATA_W-1:0]   s_tdata,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // morton_code[26:0], parent_order_offset[33:27], cell_index[61:34], zero
    output logic [ocpi_pkg::OUT_DATA_W-1:0]  m_tdata
);

    localparam int AB       = ocpi_pkg::AXIS_BITS;
    localparam int LW       = ocpi_pkg::LEVEL_W;
    localparam int CW       = ocpi_pkg::CODE_W;
    localparam int PW       = ocpi_pkg::PARENT_W;
    localparam int IW       = ocpi_pkg::INDEX_W;
    localparam int SW       = ocpi_pkg::SHIFT_W;
    localparam int NUM_GRP  = (AB + 2) / 3;
    localparam int PAD_W    = ocpi_pkg::OUT_DATA_W - CW - PW - IW;

    // configuration
    logic [LW-1:0] top_level_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            top_level_reg <= ocpi_pkg::TOP_LEVEL_RESET;
        end
        else if (cfg_wr_en)
        begin
            top_level_reg <= cfg_wr_data;
        end
    end

    // handshake chain
    logic s1_valid_reg, s2_valid_reg, s3_valid_reg;
    logic adv1, adv2, adv3;

    assign adv3     = !s3_valid_reg || m_tready;
    assign adv2     = !s2_valid_reg || adv3;
    assign adv1     = !s1_valid_reg || adv2;
    assign s_tready = adv1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            if (adv1)
            begin
                s1_valid_reg <= s_tvalid;
            end
            if (adv2)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (adv3)
            begin
                s3_valid_reg <= s2_valid_reg;
            end
        end
    end

    // stage 1: clamp levels and interleave
    ocpi_pkg::axis_t  in_x, in_y, in_z;
    ocpi_pkg::level_t in_lvl;
    logic [LW-1:0]    top_eff;
    logic [LW-1:0]    lvl_eff;
    logic [LW-1:0]    shift_full;

    logic [CW-1:0]    s1_code_reg,  s1_code_next;
    logic [LW-1:0]    s1_lvl_reg,   s1_lvl_next;
    logic [SW-1:0]    s1_shift_reg, s1_shift_next;

    always_comb
    begin
        in_x   = s_tdata[AB-1:0];
        in_y   = s_tdata[2*AB-1:AB];
        in_z   = s_tdata[3*AB-1:2*AB];
        in_lvl = s_tdata[3*AB+LW-1:3*AB];

        priority if (top_level_reg > ocpi_pkg::TOP_LEVEL_MAX)
        begin
            top_eff = ocpi_pkg::TOP_LEVEL_MAX;
        end
        else if (top_level_reg < ocpi_pkg::TOP_LEVEL_MIN)
        begin
            top_eff = ocpi_pkg::TOP_LEVEL_MIN;
        end
        else
        begin
            top_eff = top_level_reg;
        end

        lvl_eff    = (in_lvl > top_eff) ? top_eff : in_lvl;
        shift_full = top_eff - lvl_eff;

        s1_code_next  = ocpi_pkg::interleave(in_x, in_y, in_z);
        s1_lvl_next   = lvl_eff;
        s1_shift_next = shift_full[SW-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (adv1 && s_tvalid)
        begin
            s1_code_reg  <= s1_code_next;
            s1_lvl_reg   <= s1_lvl_next;
            s1_shift_reg <= s1_shift_next;
        end
    end

    // stage 2: mask, parent digit, grouped weighted sums
    logic [ocpi_pkg::SHAMT_W-1:0] shamt;
    logic [CW-1:0]                kept;
    logic [2:0]                   parent_digit;

    logic [CW-1:0]                s2_morton_reg, s2_morton_next;
    logic [PW-1:0]                s2_parent_reg, s2_parent_next;
    logic [LW-1:0]                s2_lvl_reg;
    logic [IW-1:0]                s2_sum_reg  [NUM_GRP];
    logic [IW-1:0]                s2_sum_next [NUM_GRP];

    always_comb
    begin
        shamt          = ocpi_pkg::SHAMT_W'(s1_shift_reg) * ocpi_pkg::SHAMT_W'(3);
        kept           = s1_code_reg & ({CW{1'b1}} << shamt);
        parent_digit   = s1_code_reg[shamt +: 3];
        s2_morton_next = kept;
        s2_parent_next = {s1_lvl_reg, parent_digit};
        for (int g = 0; g < NUM_GRP; g++)
        begin
            s2_sum_next[g] = '0;
            for (int j = 0; j < 3; j++)
            begin
                if (3*g + j < AB)
                begin
                    s2_sum_next[g] = s2_sum_next[g]
                        + IW'(kept[3*(3*g+j) +: 3]) * ocpi_pkg::digit_weight(3*g + j);
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv2 && s1_valid_reg)
        begin
            s2_morton_reg <= s2_morton_next;
            s2_parent_reg <= s2_parent_next;
            s2_lvl_reg    <= s1_lvl_reg;
            s2_sum_reg    <= s2_sum_next;
        end
    end

    // stage 3: final sum
    logic [CW-1:0] s3_morton_reg;
    logic [PW-1:0] s3_parent_reg;
    logic [IW-1:0] s3_index_reg, s3_index_next;

    always_comb
    begin
        s3_index_next = IW'(s2_lvl_reg);
        for (int g = 0; g < NUM_GRP; g++)
        begin
            s3_index_next = s3_index_next + s2_sum_reg[g];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv3 && s2_valid_reg)
        begin
            s3_morton_reg <= s2_morton_reg;
            s3_parent_reg <= s2_parent_reg;
            s3_index_reg  <= s3_index_next;
        end
    end

    assign m_tvalid = s3_valid_reg;
    assign m_tdata  = {{PAD_W{1'b0}}, s3_index_reg, s3_parent_reg, s3_morton_reg};

    // checks
    a_accept_fills_stage1 : assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> s1_valid_reg)
        else $error("accepted transaction did not reach stage 1");

    a_level_in_range : assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (s3_parent_reg[PW-1:3] <= ocpi_pkg::TOP_LEVEL_MAX))
        else $error("output level beyond top level");

    a_index_covers_level : assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (s3_index_reg >= IW'(s3_parent_reg[PW-1:3])))
        else $error("cell index below its level");

    a_stage3_refill : assert property (@(posedge clk) disable iff (!rst_n)
        s2_valid_reg && adv3 |=> s3_valid_reg)
        else $error("stage 2 transaction lost on advance");

endmodule
